[src/swg_pkg.sv]
package swg_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W = 16;
   localparam int LOOP_W = 12;
   localparam int OFFSET_W = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_LENGTH = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEFT_REFL = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RIGHT_REFL = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DAMPING = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DISPERSION = 3'd4;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -24'sh800000;

   // Controller states that sequence the shared datapath.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_INTERP,
      ST_AP_FWD,
      ST_AP_BACK,
      ST_DAMP_A,
      ST_DAMP_B,
      ST_REFLECT_R,
      ST_REFLECT_L,
      ST_WRITE,
      ST_OUT
   } state_type;

   // Operation selects for the datapath.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_READ,
      OP_INTERP,
      OP_AP_FWD,
      OP_AP_BACK,
      OP_DAMP_A,
      OP_DAMP_B,
      OP_REFLECT_R,
      OP_REFLECT_L,
      OP_WRITE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;
   } cmd_type;

   // Clamp a wide signed value to the 24 bit sample range.
   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [63:0] v);
      if (v > 64'(SAMPLE_MAX)) begin
         return SAMPLE_MAX;
      end else if (v < 64'(SAMPLE_MIN)) begin
         return SAMPLE_MIN;
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

[src/swg_req_if.sv]
interface swg_req_if;
   import swg_pkg::*;
   logic valid;
   logic ready;
   logic signed [SAMPLE_W-1:0] audio_in;
   logic signed [OFFSET_W-1:0] read_offset;
   modport source (output valid, audio_in, read_offset, input ready);
   modport sink (input valid, audio_in, read_offset, output ready);
endinterface

[src/swg_rsp_if.sv]
interface swg_rsp_if;
   import swg_pkg::*;
   logic valid;
   logic ready;
   logic signed [SAMPLE_W-1:0] pickup;
   modport source (output valid, pickup, input ready);
   modport sink (input valid, pickup, output ready);
endinterface

[src/swg_ctrl.sv]
module swg_ctrl
   import swg_pkg::*;
#(
   parameter int ALLPASS_STAGES = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_load,
   input  logic     rsp_busy,
   output cmd_type  cmd,
   output logic [$clog2(ALLPASS_STAGES+1)-1:0] stage
);

   localparam int STG_W = $clog2(ALLPASS_STAGES + 1);

   state_type state_ff, state_in;
   logic [STG_W-1:0] stage_ff, stage_in;

   assign stage = stage_ff;

   // Next state and stage counter.
   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_INTERP;
         ST_INTERP: begin
            stage_in = '0;
            state_in = (ALLPASS_STAGES == 0) ? ST_DAMP_A : ST_AP_FWD;
         end
         ST_AP_FWD: state_in = ST_AP_BACK;
         ST_AP_BACK: begin
            if (32'(stage_ff) == ALLPASS_STAGES - 1) begin
               state_in = ST_DAMP_A;
            end else begin
               stage_in = stage_ff + 1'b1;
               state_in = ST_AP_FWD;
            end
         end
         ST_DAMP_A: state_in = ST_DAMP_B;
         ST_DAMP_B: state_in = ST_REFLECT_R;
         ST_REFLECT_R: state_in = ST_REFLECT_L;
         ST_REFLECT_L: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs per state.
   always_comb begin
      req_ready = 1'b0;
      rsp_load = 1'b0;
      cmd.op = OP_NONE;
      cmd.load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_READ: cmd.op = OP_READ;
         ST_INTERP: cmd.op = OP_INTERP;
         ST_AP_FWD: cmd.op = OP_AP_FWD;
         ST_AP_BACK: cmd.op = OP_AP_BACK;
         ST_DAMP_A: cmd.op = OP_DAMP_A;
         ST_DAMP_B: cmd.op = OP_DAMP_B;
         ST_REFLECT_R: cmd.op = OP_REFLECT_R;
         ST_REFLECT_L: cmd.op = OP_REFLECT_L;
         ST_WRITE: cmd.op = OP_WRITE;
         ST_OUT: rsp_load = !rsp_busy;
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
      end
   end

endmodule

[src/swg_datapath.sv]
module swg_datapath
   import swg_pkg::*;
#(
   parameter int DELAY_DEPTH = 4096,
   parameter int ALLPASS_STAGES = 4
) (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   input  logic [$clog2(ALLPASS_STAGES+1)-1:0] stage,
   input  logic signed [SAMPLE_W-1:0] audio_in,
   input  logic signed [OFFSET_W-1:0] read_offset,
   input  logic [LOOP_W-1:0] loop_length,
   input  logic [COEF_W-1:0] left_reflection,
   input  logic [COEF_W-1:0] right_reflection,
   input  logic [COEF_W-1:0] damping_coeff,
   input  logic signed [COEF_W-1:0] dispersion_coeff,
   output logic clearing,
   output logic signed [SAMPLE_W-1:0] damp_out
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int PW = AW + 8;
   localparam int APN = (ALLPASS_STAGES > 0) ? ALLPASS_STAGES : 1;
   localparam int STG_W = $clog2(ALLPASS_STAGES + 1);

   logic signed [SAMPLE_W-1:0] fwd_mem [DELAY_DEPTH];
   logic signed [SAMPLE_W-1:0] bwd_mem [DELAY_DEPTH];

   logic [AW-1:0] wr_ptr_ff;
   logic [AW:0] clr_ff;
   logic signed [SAMPLE_W-1:0] ap_mem_ff [APN];
   logic signed [SAMPLE_W-1:0] damp_ff;
   logic signed [SAMPLE_W-1:0] x_ff, y_ff, f0_ff, f1_ff, ba_ff, fnew_ff, bnew_ff, xin_ff;
   logic signed [OFFSET_W-1:0] off_ff;
   logic [7:0] frac_ff;
   logic signed [63:0] acc_ff;

   logic [PW-1:0] pos;
   logic [AW-1:0] idx0, idx1, bidx;
   logic signed [SAMPLE_W-1:0] ap_s;

   assign clearing = !clr_ff[AW];
   assign damp_out = damp_ff;

   // Read position in 1/256 sample, wrapped to the line span.
   assign pos = {wr_ptr_ff, 8'd0} - {AW'(loop_length), 8'd0}
                - PW'($signed(off_ff));
   assign idx0 = pos[PW-1:8];
   assign idx1 = idx0 + 1'b1;
   assign bidx = wr_ptr_ff - AW'(loop_length);
   assign ap_s = ap_mem_ff[stage[STG_W-1:0] % APN];

   // Delay line clearing pass after reset and the stored state.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         wr_ptr_ff <= '0;
         damp_ff <= '0;
         for (int k = 0; k < APN; k++) begin
            ap_mem_ff[k] <= '0;
         end
      end else begin
         if (clearing) begin
            clr_ff <= clr_ff + 1'b1;
         end
         case (cmd.op)
            OP_AP_BACK: ap_mem_ff[stage % APN] <= sat24(64'(x_ff) -
                                                 ((64'(dispersion_coeff) *
                                                   64'(y_ff)) >>> 15));
            OP_DAMP_B: damp_ff <= sat24($signed(acc_ff + 64'(damping_coeff) *
                                                64'(damp_ff)) >>> 16);
            OP_WRITE: wr_ptr_ff <= wr_ptr_ff + 1'b1;
            default: ;
         endcase
      end
   end

   // Delay line memories: one write port, registered reads.
   always_ff @(posedge clock) begin
      if (clearing) begin
         fwd_mem[clr_ff[AW-1:0]] <= '0;
         bwd_mem[clr_ff[AW-1:0]] <= '0;
      end else if (cmd.op == OP_WRITE) begin
         fwd_mem[wr_ptr_ff] <= fnew_ff;
         bwd_mem[wr_ptr_ff] <= bnew_ff;
      end
      f0_ff <= fwd_mem[idx0];
      f1_ff <= fwd_mem[idx1];
      ba_ff <= bwd_mem[bidx];
   end

   // Sequenced arithmetic, one datapath operation per step.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xin_ff <= audio_in;
         off_ff <= read_offset;
      end
      case (cmd.op)
         OP_READ: frac_ff <= pos[7:0];
         OP_INTERP: x_ff <= SAMPLE_W'((64'(f0_ff) * 64'(256 - 32'(frac_ff)) +
                                     64'(f1_ff) * 64'(frac_ff)) >>> 8);
         OP_AP_FWD: y_ff <= sat24(((64'(dispersion_coeff) * 64'(x_ff)) >>> 15) + 64'(ap_s));
         OP_AP_BACK: x_ff <= y_ff;
         OP_DAMP_A: acc_ff <= 64'(65536 - 32'(damping_coeff)) * 64'(x_ff);
         OP_REFLECT_R: bnew_ff <= sat24($signed(-(64'(right_reflection) *
                                                  64'(damp_ff))) >>> 15);
         OP_REFLECT_L: fnew_ff <= sat24(($signed(-(64'(left_reflection) *
                                                   64'(ba_ff))) >>> 15)
                                        + 64'(xin_ff));
         default: ;
      endcase
   end

endmodule

[src/spring_waveguide_step.sv]
// Each accepted item steps through the read, interpolation, all-pass, damping, reflection
// and write states of the shared datapath; no new item is accepted until its result is loaded into the output register.
// After reset a clearing pass zeroes both delay lines; no item is
// accepted during it. Configuration registers return to their reset defaults.
module spring_waveguide_step
   import swg_pkg::*;
#(
   parameter int DELAY_DEPTH = 4096,
   parameter int ALLPASS_STAGES = 4
) (
   input  logic clock,
   input  logic reset,
   swg_req_if.sink req,
   swg_rsp_if.source rsp,
   input  logic csr_write,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type cmd;
   logic [$clog2(ALLPASS_STAGES+1)-1:0] stage;
   logic clearing, rsp_load, ctrl_ready;
   logic rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] pickup_ff, damp_out;
   logic [LOOP_W-1:0] loop_ff;
   logic [COEF_W-1:0] left_ff, right_ff, damp_c_ff;
   logic signed [COEF_W-1:0] disp_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_ff <= 12'd1024;
         left_ff <= 16'd29491;
         right_ff <= 16'd29491;
         damp_c_ff <= 16'd32768;
         disp_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LOOP_LENGTH: loop_ff <= csr_data[LOOP_W-1:0];
            CSR_LEFT_REFL: left_ff <= csr_data;
            CSR_RIGHT_REFL: right_ff <= csr_data;
            CSR_DAMPING: damp_c_ff <= csr_data;
            CSR_DISPERSION: disp_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req.ready = ctrl_ready && !clearing;

   swg_ctrl #(.ALLPASS_STAGES(ALLPASS_STAGES)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid && !clearing), .req_ready(ctrl_ready),
      .rsp_load(rsp_load), .rsp_busy(rsp_valid_ff && !rsp.ready),
      .cmd(cmd), .stage(stage)
   );

   swg_datapath #(.DELAY_DEPTH(DELAY_DEPTH), .ALLPASS_STAGES(ALLPASS_STAGES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stage(stage),
      .audio_in(req.audio_in), .read_offset(req.read_offset),
      .loop_length(loop_ff), .left_reflection(left_ff), .right_reflection(right_ff),
      .damping_coeff(damp_c_ff), .dispersion_coeff(disp_ff),
      .clearing(clearing), .damp_out(damp_out)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         pickup_ff <= damp_out;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.pickup = pickup_ff;

endmodule
